// ===== design/lphl_pkg.sv =====
// shared constants, field layout and control types for the hash lookup unit
package lphl_pkg;

  localparam int SLOTS    = 1024;
  localparam int KEY_BITS = 64;
  localparam int HASH_W   = 64;
  localparam int CFG_W    = 11;
  localparam int POS_W    = 10;
  localparam int ST_W     = 2;

  localparam int SLOT_IW  = $clog2(SLOTS);
  localparam int CAP_W    = $clog2(SLOTS + 1);
  localparam int STEP_W   = $clog2(SLOTS + 2);
  localparam int HCNT_W   = $clog2(HASH_W);

  localparam int CAP_RESET = 1024;

  // request layout, lowest bit first
  localparam int KEY_LSB   = 0;
  localparam int HASH_LSB  = 64;
  localparam int MODE_LSB  = 128;
  localparam int IDX_LSB   = 129;
  localparam int STAT_LSB  = 139;
  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 16;

  localparam logic [ST_W-1:0] ST_UNUSED  = 2'd0;
  localparam logic [ST_W-1:0] ST_DELETED = 2'd1;
  localparam logic [ST_W-1:0] ST_USED    = 2'd2;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef struct packed {
    logic clear;
    logic accept;
    logic write;
    logic div_step;
    logic probe;
    logic load_out;
  } lphl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic div_done;
    logic stop;
  } lphl_status_t;

endpackage

// ===== design/lphl_ram.sv =====
// generic single-write, single-read ram with registered read data
module lphl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lphl_datapath.sv =====
// slot stores, hash remainder unit, probe pointer and result register
module lphl_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  lphl_pkg::lphl_cmd_t              cmd,
  output lphl_pkg::lphl_status_t           status,
  input  logic [lphl_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tuser,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [lphl_pkg::CFG_W-1:0]       cfg_data,
  output logic [lphl_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import lphl_pkg::*;

  logic [CFG_W-1:0]    capacity;
  logic [CAP_W-1:0]    cap_eff;

  logic                op;
  logic [KEY_BITS-1:0] key;
  logic [HASH_W-1:0]   hash;
  logic                mode;
  logic [POS_W-1:0]    idx;
  logic [ST_W-1:0]     st;

  logic [CAP_W-1:0]    rem;
  logic [CAP_W-1:0]    rem_next;
  logic [CAP_W:0]      trial;
  logic [HCNT_W-1:0]   hcnt;

  logic [SLOT_IW-1:0]  pos;
  logic [SLOT_IW-1:0]  pos_inc;
  logic [STEP_W-1:0]   steps;
  logic [STEP_W-1:0]   steps_inc;
  logic                found;

  logic [SLOT_IW-1:0]  clr_cnt;

  logic                idx_ok;
  logic [SLOT_IW-1:0]  idx_addr;
  logic                st_we;
  logic [SLOT_IW-1:0]  st_waddr;
  logic [ST_W-1:0]     st_wdata;
  logic                key_we;
  logic [SLOT_IW-1:0]  raddr;
  logic [ST_W-1:0]     st_rd;
  logic [KEY_BITS-1:0] key_rd;

  logic                is_unused;
  logic                hit;
  logic                giveup;

  logic                res_found;
  logic                res_has_pos;
  logic [POS_W-1:0]    res_pos;

  // capacity clamp: zero acts as one, anything above the store acts as full
  always_comb begin
    if (capacity == '0) begin
      cap_eff = CAP_W'(1);
    end else if (32'(capacity) > SLOTS) begin
      cap_eff = CAP_W'(SLOTS);
    end else begin
      cap_eff = CAP_W'(capacity);
    end
  end

  // one restoring step per cycle, remainder stays below the capacity
  always_comb begin
    trial = {rem, hash[HASH_W-1]};
    if (trial >= {1'b0, cap_eff}) begin
      rem_next = CAP_W'(trial - {1'b0, cap_eff});
    end else begin
      rem_next = trial[CAP_W-1:0];
    end
  end

  always_comb begin
    if (CAP_W'(pos) + CAP_W'(1) >= cap_eff) begin
      pos_inc = '0;
    end else begin
      pos_inc = pos + SLOT_IW'(1);
    end
    steps_inc = steps + STEP_W'(1);
    is_unused = (st_rd == ST_UNUSED);
    hit       = !is_unused && (st_rd != ST_DELETED) && (key_rd == key);
    giveup    = 32'(steps_inc) > 32'(cap_eff);
  end

  assign idx_ok   = 32'(idx) < SLOTS;
  assign idx_addr = SLOT_IW'(idx);
  assign st_we    = cmd.clear || (cmd.write && idx_ok);
  assign st_waddr = cmd.clear ? clr_cnt : idx_addr;
  assign st_wdata = cmd.clear ? ST_UNUSED : st;
  assign key_we   = cmd.write && idx_ok;
  // while probing, fetch the following slot so one slot is checked per cycle
  assign raddr    = cmd.probe ? pos_inc : pos;

  assign status.clear_done = (clr_cnt == SLOT_IW'(SLOTS - 1));
  assign status.div_done   = (hcnt == HCNT_W'(HASH_W - 1));
  assign status.stop       = is_unused || hit || giveup;

  assign res_found   = (op == OP_LOOKUP) && found;
  assign res_has_pos = (op == OP_LOOKUP) && (found || mode);
  assign res_pos     = res_has_pos ? POS_W'(pos) : '0;

  lphl_ram #(
    .WIDTH (ST_W),
    .DEPTH (SLOTS)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (raddr),
    .rdata (st_rd)
  );

  lphl_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (SLOTS)
  ) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (idx_addr),
    .wdata (key),
    .raddr (raddr),
    .rdata (key_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CFG_W'(CAP_RESET);
      clr_cnt  <= '0;
      steps    <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + SLOT_IW'(1);
      end
      if (cmd.accept) begin
        steps <= '0;
      end else if (cmd.probe && !is_unused && !hit) begin
        steps <= steps_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op    <= s_tuser;
      key   <= s_tdata[KEY_LSB +: KEY_BITS];
      hash  <= s_tdata[HASH_LSB +: HASH_W];
      mode  <= s_tdata[MODE_LSB];
      idx   <= s_tdata[IDX_LSB +: POS_W];
      st    <= s_tdata[STAT_LSB +: ST_W];
      rem   <= '0;
      hcnt  <= '0;
      found <= 1'b0;
    end
    if (cmd.div_step) begin
      rem  <= rem_next;
      hash <= {hash[HASH_W-2:0], 1'b0};
      hcnt <= hcnt + HCNT_W'(1);
      if (status.div_done) begin
        pos <= SLOT_IW'(rem_next);
      end
    end
    if (cmd.probe) begin
      if (hit) begin
        found <= 1'b1;
      end else if (!is_unused) begin
        pos <= pos_inc;
      end
    end
    if (cmd.load_out) begin
      m_tdata <= OUT_TDATA_W'({res_pos, res_has_pos, res_found});
    end
  end

  a_steps_bound: assert property (@(posedge clk) disable iff (rst)
    32'(steps) <= SLOTS + 1)
    else $error("probe count ran past capacity plus one");

  a_write_result_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out && (op == OP_WRITE) |=> m_tdata == '0)
    else $error("write request produced a nonzero result");

endmodule

// ===== design/lphl_ctrl.sv =====
// sequencer: store clear, request dispatch, slot write, divide, probe and result handoff
module lphl_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output lphl_pkg::lphl_cmd_t    cmd,
  input  lphl_pkg::lphl_status_t status
);
  import lphl_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WRITE,
    S_DIV,
    S_READ,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;
  logic   s_tready_next;
  logic   m_tvalid_next;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    m_tvalid_next = m_tvalid && !m_tready;
    cmd.accept    = s_tvalid && s_tready;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd.accept) begin
          state_next = (s_tuser == OP_WRITE) ? S_WRITE : S_DIV;
        end
      end
      S_WRITE: begin
        cmd.write  = 1'b1;
        state_next = S_FINISH;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        cmd.probe = 1'b1;
        if (status.stop) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // result register frees up when empty or being taken this cycle
        if (!m_tvalid || m_tready) begin
          cmd.load_out  = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    s_tready_next = (state_next == S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      s_tready <= s_tready_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !s_tready)
    else $error("request taken during store clear");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while one is in work");

  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> m_tvalid)
    else $error("loaded result not presented");

endmodule

// ===== design/linear_probe_hash_lookup_unit.sv =====
// top level of the linear-probing hash table lookup unit
// after reset the slot status store is swept to unused, one slot per cycle,
// with no request taken (configuration writes are taken meanwhile).
// write request: the slot is written, then the result is loaded in the finish step.
// lookup: bit-serial hash remainder, a read step, then one probed slot per cycle,
// then the finish step; requests are taken again once the result is presented.
// one request in work at a time; an untaken older result holds the finish step.
module linear_probe_hash_lookup_unit (
  input  logic                             clk,
  input  logic                             rst,
  // request: search_key[63:0], probe_hash[127:64], find_mode[128],
  // slot_index[138:129], slot_status_in[140:139], zero fill above
  input  logic [lphl_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                             s_tuser,   // opcode
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // result: key_found[0], has_position[1], position[11:2], zero fill above
  output logic [lphl_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  input  logic [lphl_pkg::CFG_W-1:0]       cfg_data,  // capacity
  input  logic                             cfg_valid,
  output logic                             cfg_ready
);
  import lphl_pkg::*;

  lphl_cmd_t    cmd;
  lphl_status_t status;

  assign cfg_ready = 1'b1;

  lphl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .status   (status)
  );

  lphl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata)
  );

endmodule

// ===== dv/tb_linear_probe_hash_lookup_unit.sv =====
`timescale 1ns / 100ps
// testbench for the hash table lookup unit: directed script, random phases, scoreboard
module tb_linear_probe_hash_lookup_unit;
  import lphl_pkg::*;

  // slowest legal run is about 1450 full-wrap lookups with long stalls
  localparam int LIMIT_CYCLES   = 6_000_000;
  localparam int ITEM_TARGET    = 1450;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 1200;
  localparam int POOL_KEYS      = 8;
  localparam logic [ST_W-1:0]     ST_CODE3 = 2'd3;
  localparam logic [KEY_BITS-1:0] KEY_ONES = {KEY_BITS{1'b1}};
  localparam logic [CFG_W-1:0]    CAP_MAX  = {CFG_W{1'b1}};

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    logic                op;
    logic [KEY_BITS-1:0] key;
    logic [HASH_W-1:0]   hash;
    logic                mode;
    logic [SLOT_IW-1:0]  slot;
    logic [ST_W-1:0]     status;
  } slot_req_t;

  typedef struct {
    logic             found;
    logic             has_pos;
    logic [POS_W-1:0] pos;
    int               tag;
  } answer_t;

  typedef struct {
    row_kind_t        kind;
    slot_req_t        req;
    logic [CFG_W-1:0] cap;
    logic             typed;
    answer_t          want;
  } script_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;

  // predictor copy of the slot store and the capacity register
  logic [ST_W-1:0]     slot_status [SLOTS];
  logic [KEY_BITS-1:0] slot_key [SLOTS];
  logic [CFG_W-1:0]    capacity_reg;
  logic [KEY_BITS-1:0] key_pool [POOL_KEYS];

  answer_t     awaited_answers [$];
  script_row_t script [$];

  int  n_sent = 0, n_lookups = 0, n_hits = 0, n_stop_reports = 0, n_full_wraps = 0;
  int  n_writes = 0, n_settings = 0, mismatches = 0, cycle_count = 0;
  int  next_gap = 0;
  logic offering = 1'b0;
  logic steady_sender = 1'b0;
  int  holdoff_asked = 0, holdoff_served = 0;
  int  hold_left = 0, idle_left = 0, calm_left = 0;

  linear_probe_hash_lookup_unit u_top (
    .clk(clk),
    .rst(rst),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata(m_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .cfg_data(cfg_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready)
  );

  always #10 clk = ~clk;

  function automatic int effective_capacity(logic [CFG_W-1:0] cap);
    if (cap == 0) return 1;
    if (cap > SLOTS) return SLOTS;
    return int'(cap);
  endfunction

  // applies one request to the slot store copy and returns the answer the unit owes
  function automatic answer_t resolve_request(slot_req_t r);
    answer_t           a;
    int                cap;
    int                at;
    int                steps;
    logic              stop;
    logic [HASH_W-1:0] divisor;
    a.found   = 1'b0;
    a.has_pos = 1'b0;
    a.pos     = '0;
    a.tag     = 0;
    if (r.op == OP_WRITE) begin
      slot_status[r.slot] = r.status;
      slot_key[r.slot]    = r.key;
      n_writes++;
      return a;
    end
    n_lookups++;
    cap     = effective_capacity(capacity_reg);
    divisor = HASH_W'(cap);
    at      = int'(r.hash % divisor);
    steps   = 0;
    stop    = 1'b0;
    while (!stop) begin
      if (slot_status[at] == ST_UNUSED) begin
        stop = 1'b1;
      end else if (slot_status[at] != ST_DELETED && slot_key[at] == r.key) begin
        a.found = 1'b1;
        stop    = 1'b1;
      end else begin
        steps++;
        at = (at + 1 == cap) ? 0 : at + 1;
        // give up after capacity plus one advances
        if (steps > cap) begin
          stop = 1'b1;
          n_full_wraps++;
        end
      end
    end
    if (a.found) begin
      a.has_pos = 1'b1;
      a.pos     = POS_W'(at);
      n_hits++;
    end else if (r.mode) begin
      a.has_pos = 1'b1;
      a.pos     = POS_W'(at);
      n_stop_reports++;
    end
    return a;
  endfunction

  task automatic report_mismatch(string what, int tag, longint got, longint want);
    $display("mismatch in %s, request %0d: got %0d, expected %0d", what, tag, got, want);
    mismatches++;
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (steady_sender || p < 50) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CFG_W-1:0] pick_capacity();
    int p;
    p = $urandom_range(0, 99);
    if (p < 4) return '0;
    if (p < 8) return CFG_W'(1);
    if (p < 60) return CFG_W'($urandom_range(2, 12));
    if (p < 80) return CFG_W'($urandom_range(13, 64));
    if (p < 88) return CFG_W'($urandom_range(65, SLOTS - 1));
    if (p < 94) return CFG_W'(SLOTS);
    if (p < 97) return CAP_MAX;
    return CFG_W'($urandom_range(SLOTS + 1, 2046));
  endfunction

  // mostly pool keys on slots inside the capacity, so lookups collide, hit and wrap
  function automatic slot_req_t random_request(int eff);
    slot_req_t r;
    int        p;
    r.key    = {$urandom, $urandom};
    r.hash   = {$urandom, $urandom};
    r.mode   = 1'($urandom_range(0, 1));
    r.slot   = SLOT_IW'($urandom_range(0, SLOTS - 1));
    r.status = ST_W'($urandom_range(0, 3));
    r.op     = ($urandom_range(0, 99) < 35) ? OP_WRITE : OP_LOOKUP;
    if (r.op == OP_WRITE) begin
      if ($urandom_range(0, 9) != 0) r.slot = SLOT_IW'($urandom_range(0, eff - 1));
      p = $urandom_range(0, 99);
      r.status = (p < 55) ? ST_USED : (p < 75) ? ST_DELETED : (p < 90) ? ST_UNUSED : ST_CODE3;
      if ($urandom_range(0, 6) != 0) r.key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
    end else begin
      if ($urandom_range(0, 9) < 7) r.key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
      if ($urandom_range(0, 9) < 3) r.hash = HASH_W'($urandom_range(0, 2 * eff));
    end
    return r;
  endfunction

  function automatic void add_req(logic op, logic [KEY_BITS-1:0] key, logic [HASH_W-1:0] hash,
                                  logic mode, int slot, logic [ST_W-1:0] st, logic typed,
                                  logic f, logic h, int p);
    script_row_t row;
    row.kind         = ROW_REQ;
    row.req.op       = op;
    row.req.key      = key;
    row.req.hash     = hash;
    row.req.mode     = mode;
    row.req.slot     = SLOT_IW'(slot);
    row.req.status   = st;
    row.cap          = '0;
    row.typed        = typed;
    row.want.found   = f;
    row.want.has_pos = h;
    row.want.pos     = POS_W'(p);
    row.want.tag     = 0;
    script.push_back(row);
  endfunction

  function automatic void add_cfg(logic [CFG_W-1:0] cap);
    script_row_t row;
    row.kind  = ROW_CFG;
    row.cap   = cap;
    row.typed = 1'b0;
    script.push_back(row);
  endfunction

  // entered and left at a falling edge; valid stays high only when the next request follows
  task automatic send_request(slot_req_t r, logic typed, answer_t want);
    logic [IN_TDATA_W-1:0] word;
    answer_t               a;
    repeat (next_gap) @(negedge clk);
    word = '0;
    word[KEY_LSB +: KEY_BITS]  = r.key;
    word[HASH_LSB +: HASH_W]   = r.hash;
    word[MODE_LSB]             = r.mode;
    word[IDX_LSB +: SLOT_IW]   = r.slot;
    word[STAT_LSB +: ST_W]     = r.status;
    s_tdata  <= word;
    s_tuser  <= r.op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    a = resolve_request(r);
    if (typed) begin
      a.found   = want.found;
      a.has_pos = want.has_pos;
      a.pos     = want.pos;
    end
    a.tag = n_sent;
    n_sent++;
    awaited_answers.push_back(a);
    next_gap = pick_gap();
    @(negedge clk);
    if (next_gap != 0) s_tvalid <= 1'b0;
    offering = (next_gap == 0);
  endtask

  task automatic stop_offering();
    if (offering) begin
      s_tvalid <= 1'b0;
      offering = 1'b0;
    end
  endtask

  task automatic wait_all_answered();
    while (awaited_answers.size() != 0) @(posedge clk);
  endtask

  task automatic drain_then_set_capacity(logic [CFG_W-1:0] cap);
    stop_offering();
    wait_all_answered();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_data  <= cap;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    capacity_reg = cap;
    n_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : drive
    answer_t none;
    int      phase;
    int      phase_len;
    int      eff;
    for (int i = 0; i < SLOTS; i++) begin
      slot_status[i] = ST_UNUSED;
      slot_key[i]    = '0;
    end
    capacity_reg = CFG_W'(CAP_RESET);
    none.found   = 1'b0;
    none.has_pos = 1'b0;
    none.pos     = '0;
    none.tag     = 0;

    // written during the status clearing sweep
    add_cfg(CFG_W'(CAP_RESET));
    add_req(OP_LOOKUP, '0, '0, 1'b0, 0, ST_UNUSED, 1'b1, 1'b0, 1'b0, 0);
    add_req(OP_LOOKUP, KEY_ONES, '1, 1'b1, SLOTS - 1, ST_CODE3, 1'b1, 1'b0, 1'b1, SLOTS - 1);
    add_req(OP_WRITE, KEY_ONES, '1, 1'b1, SLOTS - 1, ST_USED, 1'b1, 1'b0, 1'b0, 0);
    add_req(OP_LOOKUP, KEY_ONES, '1, 1'b0, 0, ST_UNUSED, 1'b1, 1'b1, 1'b1, SLOTS - 1);
    // status three is compared like used
    add_req(OP_WRITE, 64'h5, '0, 1'b0, 0, ST_CODE3, 1'b1, 1'b0, 1'b0, 0);
    add_req(OP_LOOKUP, 64'h5, 64'd1024, 1'b0, 0, ST_UNUSED, 1'b1, 1'b1, 1'b1, 0);
    add_req(OP_WRITE, 64'h7, '0, 1'b0, 1, ST_DELETED, 1'b1, 1'b0, 1'b0, 0);
    add_req(OP_LOOKUP, 64'h7, 64'd1, 1'b1, 0, ST_UNUSED, 1'b0, 1'b0, 1'b0, 0);
    add_req(OP_LOOKUP, 64'h9, 64'd1023, 1'b1, 0, ST_UNUSED, 1'b0, 1'b0, 1'b0, 0);
    add_req(OP_LOOKUP, 64'h7, 64'h8000_0000_0000_0401, 1'b0, 0, ST_UNUSED, 1'b1,
            1'b0, 1'b0, 0);
    // zero capacity acts as one slot
    add_cfg('0);
    add_req(OP_LOOKUP, 64'h5, 64'h0123_4567_89ab_cdef, 1'b1, 0, ST_UNUSED, 1'b1,
            1'b1, 1'b1, 0);
    add_req(OP_LOOKUP, 64'h6, '1, 1'b1, 0, ST_UNUSED, 1'b0, 1'b0, 1'b0, 0);
    add_cfg(CAP_MAX);
    add_req(OP_LOOKUP, KEY_ONES, 64'h3ff, 1'b0, 0, ST_UNUSED, 1'b0, 1'b0, 1'b0, 0);
    // three slots all taken: the lookup gives up one past its start
    add_cfg(CFG_W'(3));
    add_req(OP_WRITE, 64'ha5a5_a5a5_a5a5_a5a5, '0, 1'b0, 2, ST_USED, 1'b1, 1'b0, 1'b0, 0);
    add_req(OP_LOOKUP, 64'h1234, '0, 1'b1, 0, ST_UNUSED, 1'b0, 1'b0, 1'b0, 0);
    add_req(OP_LOOKUP, 64'h1234, '0, 1'b0, 0, ST_UNUSED, 1'b1, 1'b0, 1'b0, 0);
    add_req(OP_LOOKUP, 64'ha5a5_a5a5_a5a5_a5a5, 64'd5, 1'b0, 0, ST_UNUSED, 1'b0,
            1'b0, 1'b0, 0);
    add_req(OP_WRITE, '0, '0, 1'b0, 2, ST_UNUSED, 1'b1, 1'b0, 1'b0, 0);
    add_req(OP_LOOKUP, 64'ha5a5_a5a5_a5a5_a5a5, 64'd2, 1'b1, 0, ST_UNUSED, 1'b0,
            1'b0, 1'b0, 0);
    add_cfg(CFG_W'(1));
    add_req(OP_LOOKUP, 64'h5, 64'hffff_0000_ffff_0000, 1'b0, 0, ST_UNUSED, 1'b1,
            1'b1, 1'b1, 0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG) drain_then_set_capacity(script[i].cap);
      else send_request(script[i].req, script[i].typed, script[i].want);
    end

    phase = 0;
    while (n_sent < ITEM_TARGET) begin
      drain_then_set_capacity(pick_capacity());
      eff = effective_capacity(capacity_reg);
      for (int k = 0; k < POOL_KEYS; k++) key_pool[k] = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) key_pool[0] = '0;
      if ($urandom_range(0, 3) == 0) key_pool[1] = KEY_ONES;
      phase_len = $urandom_range(20, 60);
      // one phase keeps offering requests while results are held off for a long stretch
      steady_sender = (phase == 2) || ($urandom_range(0, 9) == 0);
      if (phase == 2) holdoff_asked++;
      for (int k = 0; k < phase_len; k++) send_request(random_request(eff), 1'b0, none);
      steady_sender = 1'b0;
      phase++;
    end

    stop_offering();
    wait_all_answered();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests: %0d lookups (%0d hits, %0d stop slots reported, %0d full wraps)",
             n_sent, n_lookups, n_hits, n_stop_reports, n_full_wraps);
    $display("%0d slot writes, %0d capacity settings incl. zero and over-range",
             n_writes, n_settings);
    $display("one long result hold-off, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result side pacing: random stalls, quiet stretches, and the requested long hold-off
  always @(negedge clk) begin : pace_results
    int p;
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left--;
    end else if (holdoff_served != holdoff_asked) begin
      m_tready <= 1'b0;
      hold_left = HOLDOFF_CYCLES - 1;
      holdoff_served++;
    end else if (idle_left > 0) begin
      m_tready <= 1'b0;
      idle_left--;
    end else begin
      m_tready <= 1'b1;
      if (calm_left > 0) begin
        calm_left--;
      end else begin
        p = $urandom_range(0, 99);
        if (p >= 70 && p < 90) idle_left = $urandom_range(1, 3);
        else if (p >= 90 && p < 97) idle_left = $urandom_range(4, 12);
        else if (p >= 97 && p < 99) idle_left = $urandom_range(20, 60);
        else if (p == 99) calm_left = $urandom_range(100, 400);
      end
    end
  end

  always @(posedge clk) begin : check_results
    answer_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (awaited_answers.size() == 0) begin
        report_mismatch("result with no request pending", -1, m_tdata, 0);
      end else begin
        want = awaited_answers.pop_front();
        if (m_tdata[0] !== want.found)
          report_mismatch("key_found", want.tag, m_tdata[0], want.found);
        if (m_tdata[1] !== want.has_pos)
          report_mismatch("has_position", want.tag, m_tdata[1], want.has_pos);
        if (m_tdata[2 +: POS_W] !== want.pos)
          report_mismatch("position", want.tag, m_tdata[2 +: POS_W], want.pos);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("run stopped after %0d cycles with %0d results outstanding",
               cycle_count, awaited_answers.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule
